/* design/avc_pkg.sv */
// Package for the arrowhead vertex calculator.
// Widths, fixed-point constants and the stage record passed along the CORDIC chain.
// No dependencies.
package avc_pkg;

  localparam int FRACTION_BITS   = 16;
  localparam int ROTATION_STAGES = 16;

  localparam int COORD_W  = 16;
  localparam int LEN_W    = 8;
  localparam int CORNER_W = 17;
  localparam int DIFF_W   = COORD_W + 1;
  // dx*2^F grown by sqrt(2) and the CORDIC gain
  localparam int ACC_W    = DIFF_W + FRACTION_BITS + 3;
  localparam int OFS_W    = LEN_W + FRACTION_BITS + 2;
  localparam int PROD_W   = LEN_W + FRACTION_BITS;
  localparam int FIN_W    = COORD_W + FRACTION_BITS + 2;
  localparam int SHIFT_W  = $clog2(ROTATION_STAGES);

  localparam logic [LEN_W-1:0] HEAD_LENGTH_RESET = LEN_W'(10);

  // Q32 constants: converged inverse CORDIC gain and cos(30 deg)
  localparam logic [63:0] INV_GAIN_Q32 = 64'h0000_0000_9B74_EDA8;
  localparam logic [63:0] COS30_Q32    = 64'h0000_0000_DDB3_D743;
  localparam logic [63:0] CK_Q32       = (INV_GAIN_Q32 * COS30_Q32 + 64'h8000_0000) >> 32;
  localparam logic [63:0] SK_Q32       = INV_GAIN_Q32 >> 1;
  localparam logic [63:0] HALF_ULP     = 64'd1 << (31 - FRACTION_BITS);
  localparam logic [63:0] CK_FULL      = (CK_Q32 + HALF_ULP) >> (32 - FRACTION_BITS);
  localparam logic [63:0] SK_FULL      = (SK_Q32 + HALF_ULP) >> (32 - FRACTION_BITS);
  localparam logic [FRACTION_BITS-1:0] CK_FRAC = CK_FULL[FRACTION_BITS-1:0];
  localparam logic [FRACTION_BITS-1:0] SK_FRAC = SK_FULL[FRACTION_BITS-1:0];

  // added to negative values before the shift so the result truncates toward zero
  localparam logic [63:0] TRUNC_FULL = (64'd1 << FRACTION_BITS) - 64'd1;
  localparam logic [FIN_W-1:0] TRUNC_BIAS = TRUNC_FULL[FIN_W-1:0];

  typedef struct packed {
    logic signed [ACC_W-1:0]   x;
    logic signed [ACC_W-1:0]   y;
    logic signed [OFS_W-1:0]   u1;
    logic signed [OFS_W-1:0]   w1;
    logic signed [OFS_W-1:0]   u2;
    logic signed [OFS_W-1:0]   w2;
    logic signed [COORD_W-1:0] hx;
    logic signed [COORD_W-1:0] hy;
    logic                      zero;
  } avc_stage_t;

endpackage

/* design/avc_if.sv */
// Valid/ready channel interfaces for the arrowhead vertex calculator.
// Depends on avc_pkg for field widths.
interface avc_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [avc_pkg::COORD_W-1:0] tail_x;
  logic signed [avc_pkg::COORD_W-1:0] tail_y;
  logic signed [avc_pkg::COORD_W-1:0] head_x;
  logic signed [avc_pkg::COORD_W-1:0] head_y;

  modport source (output valid, output tail_x, output tail_y, output head_x, output head_y,
                  input ready);
  modport sink   (input valid, input tail_x, input tail_y, input head_x, input head_y,
                  output ready);
endinterface

interface avc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [avc_pkg::CORNER_W-1:0] first_corner_x;
  logic signed [avc_pkg::CORNER_W-1:0] first_corner_y;
  logic signed [avc_pkg::CORNER_W-1:0] second_corner_x;
  logic signed [avc_pkg::CORNER_W-1:0] second_corner_y;

  modport source (output valid, output first_corner_x, output first_corner_y,
                  output second_corner_x, output second_corner_y, input ready);
  modport sink   (input valid, input first_corner_x, input first_corner_y,
                  input second_corner_x, input second_corner_y, output ready);
endinterface

/* design/avc_front.sv */
// Front end: direction vector, scaled offsets, and quadrant pre-rotation.
// Two registered stages. Depends on avc_pkg and avc_in_if.
module avc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [avc_pkg::LEN_W-1:0]   head_length,
  avc_in_if.sink                      in_ch,
  output avc_pkg::avc_stage_t         dn_data,
  output logic                        dn_valid,
  input  logic                        dn_ready
);

  // stage A
  logic                                 a_valid_r;
  logic signed [avc_pkg::DIFF_W-1:0]    a_dx_r, a_dy_r;
  logic signed [avc_pkg::OFS_W-1:0]     a_cu_r, a_sw_r;
  logic signed [avc_pkg::COORD_W-1:0]   a_hx_r, a_hy_r;
  logic                                 a_zero_r;
  logic                                 a_ready;

  logic signed [avc_pkg::DIFF_W-1:0]    dx_nxt, dy_nxt;
  logic        [avc_pkg::PROD_W-1:0]    cu_prod, sw_prod;

  // stage B
  logic                                 b_valid_r;
  avc_pkg::avc_stage_t                  b_data_r;
  avc_pkg::avc_stage_t                  b_data_nxt;
  logic                                 b_ready;

  logic signed [avc_pkg::ACC_W-1:0]     xp, yp, xn, yn;
  logic signed [avc_pkg::OFS_W-1:0]     cu, sw;

  assign b_ready     = !b_valid_r || dn_ready;
  assign a_ready     = !a_valid_r || b_ready;
  assign in_ch.ready = a_ready;

  assign dx_nxt  = avc_pkg::DIFF_W'(in_ch.head_x) - avc_pkg::DIFF_W'(in_ch.tail_x);
  assign dy_nxt  = avc_pkg::DIFF_W'(in_ch.head_y) - avc_pkg::DIFF_W'(in_ch.tail_y);
  assign cu_prod = head_length * avc_pkg::CK_FRAC;
  assign sw_prod = head_length * avc_pkg::SK_FRAC;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_ch.valid) begin
      a_dx_r   <= dx_nxt;
      a_dy_r   <= dy_nxt;
      a_cu_r   <= avc_pkg::OFS_W'(cu_prod);
      a_sw_r   <= avc_pkg::OFS_W'(sw_prod);
      a_hx_r   <= in_ch.head_x;
      a_hy_r   <= in_ch.head_y;
      a_zero_r <= (dx_nxt == '0) && (dy_nxt == '0);
    end
  end

  // fixed-point direction vector and its negations
  assign xp = avc_pkg::ACC_W'(a_dx_r) <<< avc_pkg::FRACTION_BITS;
  assign yp = avc_pkg::ACC_W'(a_dy_r) <<< avc_pkg::FRACTION_BITS;
  assign xn = avc_pkg::ACC_W'(-a_dx_r) <<< avc_pkg::FRACTION_BITS;
  assign yn = avc_pkg::ACC_W'(-a_dy_r) <<< avc_pkg::FRACTION_BITS;
  assign cu = a_cu_r;
  assign sw = a_sw_r;

  // left half plane: quarter turn on both the vector and the offsets
  always_comb begin
    b_data_nxt      = '0;
    b_data_nxt.hx   = a_hx_r;
    b_data_nxt.hy   = a_hy_r;
    b_data_nxt.zero = a_zero_r;
    if (!a_dx_r[avc_pkg::DIFF_W-1]) begin
      b_data_nxt.x  = xp;
      b_data_nxt.y  = yp;
      b_data_nxt.u1 = cu;
      b_data_nxt.w1 = sw;
      b_data_nxt.u2 = cu;
      b_data_nxt.w2 = -sw;
    end else if (!a_dy_r[avc_pkg::DIFF_W-1]) begin
      b_data_nxt.x  = yp;
      b_data_nxt.y  = xn;
      b_data_nxt.u1 = -sw;
      b_data_nxt.w1 = cu;
      b_data_nxt.u2 = sw;
      b_data_nxt.w2 = cu;
    end else begin
      b_data_nxt.x  = yn;
      b_data_nxt.y  = xp;
      b_data_nxt.u1 = sw;
      b_data_nxt.w1 = -cu;
      b_data_nxt.u2 = -sw;
      b_data_nxt.w2 = -cu;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid_r) begin
      b_data_r <= b_data_nxt;
    end
  end

  assign dn_data  = b_data_r;
  assign dn_valid = b_valid_r;

endmodule

/* design/avc_cell.sv */
// One CORDIC micro-rotation cell: vectoring on (x, y), same turn on both offsets.
// Registered, with its own valid bit. Depends on avc_pkg.
module avc_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [avc_pkg::SHIFT_W-1:0]   shift,
  input  avc_pkg::avc_stage_t           up_data,
  input  logic                          up_valid,
  output logic                          up_ready,
  output avc_pkg::avc_stage_t           dn_data,
  output logic                          dn_valid,
  input  logic                          dn_ready
);

  logic                  valid_r;
  avc_pkg::avc_stage_t   data_r;
  avc_pkg::avc_stage_t   data_nxt;

  logic signed [avc_pkg::ACC_W-1:0] xs, ys;
  logic signed [avc_pkg::OFS_W-1:0] u1s, w1s, u2s, w2s;
  logic                             pos;

  assign up_ready = !valid_r || dn_ready;

  assign pos = !up_data.y[avc_pkg::ACC_W-1];
  assign xs  = up_data.x  >>> shift;
  assign ys  = up_data.y  >>> shift;
  assign u1s = up_data.u1 >>> shift;
  assign w1s = up_data.w1 >>> shift;
  assign u2s = up_data.u2 >>> shift;
  assign w2s = up_data.w2 >>> shift;

  always_comb begin
    data_nxt = up_data;
    if (!up_data.zero) begin
      if (pos) begin
        data_nxt.x  = up_data.x  + ys;
        data_nxt.y  = up_data.y  - xs;
        data_nxt.u1 = up_data.u1 - w1s;
        data_nxt.w1 = up_data.w1 + u1s;
        data_nxt.u2 = up_data.u2 - w2s;
        data_nxt.w2 = up_data.w2 + u2s;
      end else begin
        data_nxt.x  = up_data.x  - ys;
        data_nxt.y  = up_data.y  + xs;
        data_nxt.u1 = up_data.u1 + w1s;
        data_nxt.w1 = up_data.w1 - u1s;
        data_nxt.u2 = up_data.u2 + w2s;
        data_nxt.w2 = up_data.w2 - u2s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_data  = data_r;
  assign dn_valid = valid_r;

endmodule

/* design/avc_back.sv */
// Back end: head minus rotated offsets, truncated toward zero, into the output register.
// Depends on avc_pkg and avc_out_if.
module avc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  avc_pkg::avc_stage_t   up_data,
  input  logic                  up_valid,
  output logic                  up_ready,
  avc_out_if.source             out_ch
);

  logic                                  out_valid_r;
  logic signed [avc_pkg::CORNER_W-1:0]   c1x_r, c1y_r, c2x_r, c2y_r;

  function automatic logic [avc_pkg::CORNER_W-1:0] corner (
    input logic signed [avc_pkg::COORD_W-1:0] h,
    input logic signed [avc_pkg::OFS_W-1:0]   o
  );
    logic signed [avc_pkg::FIN_W-1:0] v;
    logic signed [avc_pkg::FIN_W-1:0] adj;
    logic signed [avc_pkg::FIN_W-1:0] sh;
    v   = (avc_pkg::FIN_W'(h) <<< avc_pkg::FRACTION_BITS) - avc_pkg::FIN_W'(o);
    adj = v[avc_pkg::FIN_W-1] ? (v + avc_pkg::TRUNC_BIAS) : v;
    sh  = adj >>> avc_pkg::FRACTION_BITS;
    return sh[avc_pkg::CORNER_W-1:0];
  endfunction

  assign up_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (up_ready) begin
      out_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      c1x_r <= corner(up_data.hx, up_data.u1);
      c1y_r <= corner(up_data.hy, up_data.w1);
      c2x_r <= corner(up_data.hx, up_data.u2);
      c2y_r <= corner(up_data.hy, up_data.w2);
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.first_corner_x  = c1x_r;
  assign out_ch.first_corner_y  = c1y_r;
  assign out_ch.second_corner_x = c2x_r;
  assign out_ch.second_corner_y = c2y_r;

endmodule

/* design/arrowhead_vertex_calculator_unit.sv */
// Arrowhead vertex calculator: arrow tail/head in, two arrowhead corners out.
// From input transaction to result valid: two front stages, one cell per CORDIC
// micro-rotation, one output register (19 registers, the first loaded at the accepting edge).
// Throughput: one arrow per cycle while out_ch.ready stays high; every stage has its own
// valid bit, so bubbles close up.
// Reset (rst_n low, synchronous): pipeline emptied, head_length back to 10.
module arrowhead_vertex_calculator_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [avc_pkg::LEN_W-1:0]   cfg_wdata,
  avc_in_if.sink                      in_ch,
  avc_out_if.source                   out_ch
);

  logic [avc_pkg::LEN_W-1:0] head_length_r;

  avc_pkg::avc_stage_t stg_data  [avc_pkg::ROTATION_STAGES+1];
  logic                stg_valid [avc_pkg::ROTATION_STAGES+1];
  logic                stg_ready [avc_pkg::ROTATION_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_length_r <= avc_pkg::HEAD_LENGTH_RESET;
    end else if (cfg_we) begin
      head_length_r <= cfg_wdata;
    end
  end

  avc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_length (head_length_r),
    .in_ch       (in_ch),
    .dn_data     (stg_data[0]),
    .dn_valid    (stg_valid[0]),
    .dn_ready    (stg_ready[0])
  );

  for (genvar i = 0; i < avc_pkg::ROTATION_STAGES; i++) begin : g_cell
    avc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (avc_pkg::SHIFT_W'(i)),
      .up_data  (stg_data[i]),
      .up_valid (stg_valid[i]),
      .up_ready (stg_ready[i]),
      .dn_data  (stg_data[i+1]),
      .dn_valid (stg_valid[i+1]),
      .dn_ready (stg_ready[i+1])
    );
  end

  avc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_data  (stg_data[avc_pkg::ROTATION_STAGES]),
    .up_valid (stg_valid[avc_pkg::ROTATION_STAGES]),
    .up_ready (stg_ready[avc_pkg::ROTATION_STAGES]),
    .out_ch   (out_ch)
  );

endmodule
